FILE: hw/rtl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants for the biquad filter chain.
// ----------------------------------------------------------------------------
package sbq_pkg;

    localparam int COEF_W  = 32;
    localparam int DELAY_W = 40;
    localparam int PROD_W  = 64;

    // coefficient slot codes
    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;
    localparam logic [2:0] NUM_SLOTS = 3'd5;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // multiply-accumulate unit command
    typedef struct packed {
        logic                      start;
        logic signed [COEF_W-1:0]  coef;
        logic signed [DELAY_W-1:0] operand;
    } t_mac_cmd;

endpackage

FILE: hw/rtl/sbq_mac.sv
// ----------------------------------------------------------------------------
// sbq_mac
// Shared rounded multiplier: r(c*x) = (c*x + 2^(F-1)) >>> F, in registered
// steps (operand capture, 32x32 partial product halves, then sum and round).
// ----------------------------------------------------------------------------
module sbq_mac
    import sbq_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_cmd                   i_cmd,
    output logic                       o_done,
    output logic signed [DELAY_W-1:0]  o_result
);

    // operand split: low 20 bits unsigned, high part signed
    localparam int LO_W = 20;

    logic signed [COEF_W-1:0]        r_coef;
    logic signed [DELAY_W-LO_W:0]    r_hi;
    logic        [LO_W-1:0]          r_lo;
    logic signed [PROD_W-1:0]        r_plo;
    logic signed [PROD_W-1:0]        r_phi;
    logic                            r_v0;
    logic                            r_v1;
    logic                            r_v2;
    logic signed [PROD_W-1:0]        n_sum;
    logic signed [PROD_W-1:0]        r_sum;

    // stage 0: capture operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
        r_coef <= i_cmd.coef;
        r_hi   <= {i_cmd.operand[DELAY_W-1], i_cmd.operand[DELAY_W-1:LO_W]};
        r_lo   <= i_cmd.operand[LO_W-1:0];
        // stage 1: two partial products, each within 32x32
        r_plo  <= PROD_W'(r_coef * $signed({1'b0, r_lo}));
        r_phi  <= PROD_W'(r_coef * r_hi);
        // stage 2: combine and round
        r_sum  <= n_sum;
    end

    always_comb begin
        n_sum = (r_phi <<< LO_W) + r_plo + (PROD_W'(1) <<< (COEF_FRAC_BITS - 1));
    end

    assign o_done   = r_v2;
    assign o_result = DELAY_W'(r_sum >>> COEF_FRAC_BITS);

endmodule

FILE: hw/rtl/semg_biquad_filter_chain_top.sv
// ----------------------------------------------------------------------------
// semg_biquad_filter_chain_top
// Multichannel transposed DF2 biquad cascade: high-pass, low-pass, notches.
// ----------------------------------------------------------------------------
// A sample transaction runs stage by stage through one shared rounded
// multiplier: each stage issues five products in turn and waits for each
// (read, issue, wait), then runs its output and writeback steps. The chain
// has 2+active_notches stages (active_notches capped at MAX_NOTCHES), and
// the next transaction is taken only once the result has been passed to the
// output register; a coefficient write is taken while idle. Delay state
// lives in a memory of CHANNELS*(MAX_NOTCHES+2) words, cleared by a pass
// after reset, during which no transaction is accepted. Coefficients
// must be written before samples are sent. Results wait in an output register
// while the next transaction is taken.
module semg_biquad_filter_chain_top
    import sbq_pkg::*;
#(
    parameter int CHANNELS       = 16,
    parameter int MAX_NOTCHES    = 10,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,           // active_notches
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // channel[3:0], sample_in[4+:SB], coef_stage, coef_slot, coef_value, pad
    input  logic [((4+SAMPLE_BITS+4+3+32+7)/8)*8-1:0] s_axis_tdata,
    input  logic        s_axis_tuser,          // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_channel[3:0], bandpass_sample, notched_sample, pad
    output logic [((4+2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int STAGES   = MAX_NOTCHES + 2;
    localparam int STG_W    = $clog2(STAGES + 1);
    localparam int CWORDS   = STAGES * 5;
    localparam int CA_W     = $clog2(CWORDS);
    localparam int DWORDS   = CHANNELS * STAGES;
    localparam int DA_W     = $clog2(DWORDS);
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SB       = SAMPLE_BITS;
    localparam int O_STG    = 4 + SB;
    localparam int O_SLOT   = O_STG + 4;
    localparam int O_VAL    = O_SLOT + 3;
    localparam int OUT_W    = ((4+2*SB+7)/8)*8;
    localparam logic signed [DELAY_W-1:0] S_MAX = DELAY_W'((64'sd1 <<< (SB-1)) - 1);
    localparam logic signed [DELAY_W-1:0] S_MIN = -S_MAX - DELAY_W'(1);
    localparam logic signed [DELAY_W+1:0] D_MAX = (DELAY_W+2)'((64'sd1 <<< (DELAY_W-1)) - 1);
    localparam logic signed [DELAY_W+1:0] D_MIN = -D_MAX - (DELAY_W+2)'(1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_ISSUE, ST_WAIT, ST_Y, ST_WB, ST_OUT
    } t_state;

    // memories: coefficients, and delay pairs {d2, d1} per channel and stage
    logic signed [COEF_W-1:0]      coef_mem [CWORDS];
    logic        [2*DELAY_W-1:0]   dly_mem  [DWORDS];

    t_state                        r_state;
    logic [DA_W-1:0]               r_clr;
    logic [3:0]                    r_notch;
    logic [CH_W-1:0]               r_ch;
    logic [STG_W-1:0]              r_stg;
    logic [STG_W-1:0]              r_last;
    logic [2:0]                    r_slot;
    logic signed [DELAY_W-1:0]     r_x;
    logic signed [DELAY_W-1:0]     r_y;
    logic signed [DELAY_W-1:0]     r_bp;
    logic signed [DELAY_W-1:0]     r_d1;
    logic signed [DELAY_W-1:0]     r_d2;
    logic signed [DELAY_W-1:0]     r_p [5];
    logic signed [COEF_W-1:0]      r_coef_rd;
    logic [2*DELAY_W-1:0]          r_dly_rd;
    logic                          r_out_v;
    logic [OUT_W-1:0]              r_out;
    t_mac_cmd                      mac_cmd;
    logic                          mac_done;
    logic signed [DELAY_W-1:0]     mac_res;
    logic [3:0]                    in_stage;
    logic [2:0]                    in_slot;
    logic [3:0]                    in_ch;
    logic [DA_W-1:0]               dly_idx;
    logic [CA_W-1:0]               coef_idx;
    logic signed [DELAY_W+1:0]     n_d1;
    logic signed [DELAY_W+1:0]     n_d2;
    logic signed [DELAY_W:0]       n_ysum;
    logic signed [DELAY_W-1:0]     n_y;
    logic [3:0]                    notch_eff;

    assign in_stage  = s_axis_tdata[O_STG +: 4];
    assign in_slot   = s_axis_tdata[O_SLOT +: 3];
    assign in_ch     = s_axis_tdata[3:0];
    assign notch_eff = (32'(r_notch) > MAX_NOTCHES) ? 4'(MAX_NOTCHES) : r_notch;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign dly_idx   = DA_W'(32'(r_ch) * STAGES + 32'(r_stg));
    assign coef_idx  = CA_W'(32'(r_stg) * 5 + 32'(r_slot));

    // stage arithmetic from the finished products
    always_comb begin
        n_ysum = (DELAY_W+1)'(r_p[0]) + (DELAY_W+1)'($signed(r_dly_rd[DELAY_W-1:0]));
        if (n_ysum > (DELAY_W+1)'(S_MAX))      n_y = S_MAX;
        else if (n_ysum < (DELAY_W+1)'(S_MIN)) n_y = S_MIN;
        else                                   n_y = DELAY_W'(n_ysum);
        n_d1 = (DELAY_W+2)'(r_p[1]) - (DELAY_W+2)'(r_p[3])
             + (DELAY_W+2)'($signed(r_dly_rd[2*DELAY_W-1:DELAY_W]));
        n_d2 = (DELAY_W+2)'(r_p[2]) - (DELAY_W+2)'(r_p[4]);
    end

    // operands: y-dependent slots use the stage output
    always_comb begin
        mac_cmd.start   = (r_state == ST_ISSUE);
        mac_cmd.coef    = r_coef_rd;
        mac_cmd.operand = (r_slot >= SLOT_A1) ? r_y : r_x;
    end

    sbq_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mac_cmd),
        .o_done   (mac_done),
        .o_result (mac_res)
    );

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_COEF
            && 32'(in_stage) < STAGES && in_slot < NUM_SLOTS) begin
            coef_mem[CA_W'(32'(in_stage) * 5 + 32'(in_slot))] <=
                s_axis_tdata[O_VAL +: 32];
        end
        r_coef_rd <= coef_mem[coef_idx];
    end

    // delay memory: clear pass, then writeback per stage
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            dly_mem[r_clr[DA_W-1:0]] <= '0;
        end else if (r_state == ST_WB) begin
            dly_mem[dly_idx] <= {
                (n_d2 > D_MAX) ? D_MAX[DELAY_W-1:0] :
                (n_d2 < D_MIN) ? D_MIN[DELAY_W-1:0] : n_d2[DELAY_W-1:0],
                (n_d1 > D_MAX) ? D_MAX[DELAY_W-1:0] :
                (n_d1 < D_MIN) ? D_MIN[DELAY_W-1:0] : n_d1[DELAY_W-1:0]};
        end
        r_dly_rd <= dly_mem[dly_idx];
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_notch <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) r_notch <= i_cfg_wdata;
            if (m_axis_tready && r_state != ST_OUT) r_out_v <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + DA_W'(1);
                    if (32'(r_clr) == DWORDS - 1) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_SAMPLE
                        && 32'(in_ch) < CHANNELS) begin
                        r_ch    <= CH_W'(in_ch);
                        r_x     <= DELAY_W'($signed(s_axis_tdata[4 +: SB]));
                        r_stg   <= '0;
                        r_last  <= STG_W'(32'(notch_eff) + 1);
                        r_slot  <= SLOT_B0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    // memory reads for the current slot settle here
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (mac_done) begin
                        r_p[r_slot] <= mac_res;
                        if (r_slot == SLOT_B2) r_state <= ST_Y;
                        else if (r_slot == SLOT_A2) r_state <= ST_WB;
                        else begin
                            r_slot  <= r_slot + 3'd1;
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_Y: begin
                    r_y     <= n_y;
                    r_slot  <= SLOT_A1;
                    r_state <= ST_RD;
                end
                ST_WB: begin
                    if (r_stg == STG_W'(1)) r_bp <= r_y;
                    r_x    <= r_y;
                    r_slot <= SLOT_B0;
                    if (r_stg == r_last) r_state <= ST_OUT;
                    else begin
                        r_stg   <= r_stg + STG_W'(1);
                        r_state <= ST_RD;
                    end
                end
                ST_OUT: begin
                    if (!r_out_v || m_axis_tready) begin
                        r_out_v <= 1'b1;
                        r_out   <= OUT_W'({r_y[SB-1:0], r_bp[SB-1:0], 4'(r_ch)});
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

    // the stage chain never runs past the last notch
    a_stage_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WB |-> 32'(r_stg) < STAGES)
        else $error("stage index beyond chain");
    // a result appears only after a finished chain
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_state) == ST_OUT)
        else $error("result without chain");
    // no multiply completes while the sequencer is idle
    a_mac_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> r_state == ST_WAIT)
        else $error("stray product");

endmodule
